// ===== rtl/fqvr_pkg.sv =====
// shared types, sizes and codes for the value-removal fifo queue
package fqvr_pkg;

    // ring size and derived widths
    localparam int DEPTH = 16;
    localparam int IW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    typedef logic [IW-1:0] t_idx;
    typedef logic [CW-1:0] t_cnt;

    // request codes
    typedef enum logic [1:0] {
        REQ_PUSH   = 2'd0,
        REQ_POP    = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_QUERY  = 2'd3
    } t_req_code;

    // status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // input beat
    typedef struct packed {
        t_req_code          req_type;
        logic signed [31:0] value;
    } t_req;

    // output beat
    typedef struct packed {
        logic signed [31:0] head_value;
        logic signed [31:0] tail_value;
        logic               is_empty;
        logic [4:0]         entry_total;
        t_status            status;
        logic [4:0]         removed_total;
    } t_rsp;

    // ring store write port
    typedef struct packed {
        logic               we;
        t_idx               addr;
        logic signed [31:0] data;
    } t_mem_wr;

    // ring store read port
    typedef struct packed {
        logic re;
        t_idx addr;
    } t_mem_rd;

    // ring position at an offset from the head, offset below DEPTH
    function automatic t_idx f_slot(t_idx head, t_cnt off);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return IW'(sum);
    endfunction

endpackage

// ===== rtl/fifo_queue_with_value_removal.sv =====
// fifo queue of signed 32-bit values with remove-all-equal, top level
// pop reads the new head back from the store; remove walks the N held entries
//   in order, one store read per cycle
// flow: one request at a time; next beat taken once the result moves to
//   the output register, which may still be waiting on the far side
// reset: synchronous active-low; queue empty, head at ring position zero
module fifo_queue_with_value_removal (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  fqvr_pkg::t_req i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output fqvr_pkg::t_rsp o_out_data
);
    import fqvr_pkg::*;

    t_mem_wr            mem_wr;
    t_mem_rd            mem_rd;
    logic signed [31:0] mem_rdata;
    logic               res_vld;
    t_rsp               res;
    logic               res_take;
    logic               r_out_vld;
    t_rsp               r_out;

    // output register is free when empty or being drained
    assign res_take = !r_out_vld || !i_out_stall;

    fqvr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_res_vld  (res_vld),
        .o_res      (res),
        .i_res_take (res_take),
        .o_wr       (mem_wr),
        .o_rd       (mem_rd),
        .i_rdata    (mem_rdata)
    );

    fqvr_store u_store (
        .i_clk   (i_clk),
        .i_wr    (mem_wr),
        .i_rd    (mem_rd),
        .o_rdata (mem_rdata)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_vld && res_take) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_vld && res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/fqvr_store.sv =====
// ring store: one write port, one registered read port
module fqvr_store (
    input  logic               i_clk,
    input  fqvr_pkg::t_mem_wr  i_wr,
    input  fqvr_pkg::t_mem_rd  i_rd,
    output logic signed [31:0] o_rdata
);
    import fqvr_pkg::*;

    logic signed [31:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd.re) begin
            o_rdata <= r_mem[i_rd.addr];
        end
    end

endmodule

// ===== rtl/fqvr_ctrl.sv =====
// request sequencer: queue pointers, removal walk and compare unit
module fqvr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  fqvr_pkg::t_req     i_in_data,
    output logic               o_in_stall,
    output logic               o_res_vld,
    output fqvr_pkg::t_rsp     o_res,
    input  logic               i_res_take,
    output fqvr_pkg::t_mem_wr  o_wr,
    output fqvr_pkg::t_mem_rd  o_rd,
    input  logic signed [31:0] i_rdata
);
    import fqvr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POPRD,
        S_WALK,
        S_DONE
    } t_state;

    t_state             r_state;
    t_idx               r_head;
    t_cnt               r_cnt;
    logic signed [31:0] r_head_val;
    logic signed [31:0] r_tail_val;
    t_status            r_status;
    t_cnt               r_removed;
    logic signed [31:0] r_ref;
    t_cnt               r_rd;
    t_cnt               r_wr;
    logic               r_pend;

    logic full;
    logic keep;
    logic rd_more;

    assign full    = (r_cnt == t_cnt'(DEPTH));
    assign rd_more = (r_rd != r_cnt);
    // shared compare unit: entry survives the walk when it differs
    assign keep    = r_pend && (i_rdata != r_ref);

    assign o_in_stall = (r_state != S_IDLE);

    // ring store requests
    always_comb begin
        o_wr = '0;
        o_rd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_in_data.req_type == REQ_PUSH && !full) begin
                    o_wr.we   = 1'b1;
                    o_wr.addr = f_slot(r_head, r_cnt);
                    o_wr.data = i_in_data.value;
                end
                if (i_in_valid && i_in_data.req_type == REQ_POP && r_cnt != '0) begin
                    o_rd.re   = 1'b1;
                    o_rd.addr = f_slot(r_head, t_cnt'(1));
                end
            end
            S_WALK: begin
                if (rd_more) begin
                    o_rd.re   = 1'b1;
                    o_rd.addr = f_slot(r_head, r_rd);
                end
                if (keep) begin
                    o_wr.we   = 1'b1;
                    o_wr.addr = f_slot(r_head, r_wr);
                    o_wr.data = i_rdata;
                end
            end
            S_POPRD, S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // result beat
    always_comb begin
        o_res_vld           = (r_state == S_DONE);
        o_res.head_value    = (r_cnt == '0) ? '0 : r_head_val;
        o_res.tail_value    = (r_cnt == '0) ? '0 : r_tail_val;
        o_res.is_empty      = (r_cnt == '0);
        o_res.entry_total   = 5'(r_cnt);
        o_res.status        = r_status;
        o_res.removed_total = 5'(r_removed);
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_removed <= '0;
                        r_status  <= ST_OK;
                        r_state   <= S_DONE;
                        unique case (i_in_data.req_type)
                            REQ_PUSH: begin
                                if (full) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_cnt      <= r_cnt + t_cnt'(1);
                                    r_tail_val <= i_in_data.value;
                                    if (r_cnt == '0) begin
                                        r_head_val <= i_in_data.value;
                                    end
                                end
                            end
                            REQ_POP: begin
                                if (r_cnt == '0) begin
                                    r_status <= ST_EMPTY;
                                end else begin
                                    r_head  <= f_slot(r_head, t_cnt'(1));
                                    r_cnt   <= r_cnt - t_cnt'(1);
                                    r_state <= S_POPRD;
                                end
                            end
                            REQ_REMOVE: begin
                                if (r_cnt == '0) begin
                                    r_status <= ST_EMPTY;
                                end else begin
                                    r_ref   <= i_in_data.value;
                                    r_rd    <= '0;
                                    r_wr    <= '0;
                                    r_pend  <= 1'b0;
                                    r_state <= S_WALK;
                                end
                            end
                            REQ_QUERY: begin
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_POPRD: begin
                    // new head arrives from the store
                    r_head_val <= i_rdata;
                    r_state    <= S_DONE;
                end
                S_WALK: begin
                    // one read issued and one entry compared per cycle; kept entries are written back
                    r_pend <= rd_more;
                    if (rd_more) begin
                        r_rd <= r_rd + t_cnt'(1);
                    end
                    if (keep) begin
                        r_wr       <= r_wr + t_cnt'(1);
                        r_tail_val <= i_rdata;
                        if (r_wr == '0) begin
                            r_head_val <= i_rdata;
                        end
                    end
                    if (!rd_more && !r_pend) begin
                        r_cnt     <= r_wr;
                        r_removed <= r_cnt - r_wr;
                        r_status  <= (r_cnt == r_wr) ? ST_NOT_FOUND : ST_OK;
                        r_state   <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_res_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/fqvr_checker.sv =====
// port checker for the value-removal fifo queue and its bind
module fqvr_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input fqvr_pkg::t_req i_in_data,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input fqvr_pkg::t_rsp o_out_data
);
    import fqvr_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // empty queue reports zeros
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.is_empty |->
            o_out_data.head_value == '0 && o_out_data.tail_value == '0 &&
            o_out_data.entry_total == '0)
        else $error("empty queue with nonzero fields");

    // a dropped push or a missed removal leaves entries behind
    a_status_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_FULL ||
                        o_out_data.status == ST_NOT_FOUND) |->
            !o_out_data.is_empty)
        else $error("full or not-found status on an empty queue");

    // removals only come with an ok status
    a_removed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.removed_total != '0 |->
            o_out_data.status == ST_OK)
        else $error("removed entries without ok status");

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind fifo_queue_with_value_removal fqvr_checker u_fqvr_checker (.*);

// ===== tb/fifo_queue_with_value_removal_tb.sv =====
// self-checking testbench for the value-removal fifo queue: directed corners, then random traffic
`timescale 1ns / 100ps

module fifo_queue_with_value_removal_tb;
    import fqvr_pkg::*;

    // clock, reset and block ports
    logic i_clk      = 1'b0;
    logic i_rst_n    = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_out_stall = 1'b0;
    t_req i_in_data  = '0;
    logic o_in_stall;
    logic o_out_valid;
    t_rsp o_out_data;

    // idling controls for the sender and the receiver
    int unsigned snd_idle_pct  = 0;
    int unsigned rcv_stall_pct = 0;
    int unsigned mismatch_count = 0;

    // queue contents as seen from outside, and the results still owed
    logic signed [31:0] model_ring [DEPTH];
    int unsigned        model_head = 0;
    int unsigned        model_held = 0;
    t_rsp               pending_rsp [$];

    // drain direction for random traffic, flips now and then
    bit fill_trend = 1'b1;

    fifo_queue_with_value_removal dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    // ring position at an offset from the head
    function automatic int unsigned ring_pos(int unsigned off);
        return (model_head + off) % DEPTH;
    endfunction

    // apply one request to the queue copy and build the result it produces
    function automatic t_rsp apply_request(t_req req);
        t_rsp        rsp;
        int unsigned kept;
        rsp        = '0;
        rsp.status = ST_OK;
        case (req.req_type)
            REQ_PUSH: begin
                if (model_held >= DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    model_ring[ring_pos(model_held)] = req.value;
                    model_held++;
                end
            end
            REQ_POP: begin
                if (model_held == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    model_head = ring_pos(1);
                    model_held--;
                end
            end
            REQ_REMOVE: begin
                if (model_held == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    // single in-order compaction pass
                    kept = 0;
                    for (int unsigned rd = 0; rd < model_held; rd++) begin
                        if (model_ring[ring_pos(rd)] != req.value) begin
                            model_ring[ring_pos(kept)] = model_ring[ring_pos(rd)];
                            kept++;
                        end
                    end
                    rsp.removed_total = 5'(model_held - kept);
                    if (kept == model_held) begin
                        rsp.status = ST_NOT_FOUND;
                    end
                    model_held = kept;
                end
            end
            default: begin
            end
        endcase
        if (model_held == 0) begin
            rsp.is_empty = 1'b1;
        end else begin
            rsp.head_value = model_ring[ring_pos(0)];
            rsp.tail_value = model_ring[ring_pos(model_held - 1)];
        end
        rsp.entry_total = 5'(model_held);
        return rsp;
    endfunction

    // one field of a result against its expectation
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // result checker: every accepted output beat against the oldest expectation
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, o_out_data);
                mismatch_count++;
            end else begin
                want = pending_rsp.pop_front();
                check_field("head_value", want.head_value, o_out_data.head_value);
                check_field("tail_value", want.tail_value, o_out_data.tail_value);
                check_field("is_empty", 32'(want.is_empty), 32'(o_out_data.is_empty));
                check_field("entry_total", 32'(want.entry_total),
                            32'(o_out_data.entry_total));
                check_field("status", 32'(want.status), 32'(o_out_data.status));
                check_field("removed_total", 32'(want.removed_total),
                            32'(o_out_data.removed_total));
            end
        end
    end

    // sender idle length for the current phase
    function automatic int unsigned pick_gap();
        int unsigned gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < snd_idle_pct) begin
            gap++;
        end
        return gap;
    endfunction

    // send one request beat and record the result it owes; entered at a clock edge
    task automatic send_req(t_req_code kind, logic signed [31:0] val);
        int unsigned gap;
        t_req        req;
        gap = pick_gap();
        req.req_type = kind;
        req.value    = val;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do begin
            @(posedge i_clk);
        end while (!(i_in_valid && !o_in_stall));
        pending_rsp.push_back(apply_request(req));
    endtask

    // hold the sender off until every owed result has come back
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_rsp.size() != 0);
    endtask

    // mostly small values so removals find matches, plus full-range and extremes
    function automatic logic signed [31:0] random_value();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return 32'($signed($urandom_range(7)) - 3);
            5, 6, 7:       return $urandom;
            8:             return 32'sh8000_0000;
            default:       return 32'sh7fff_ffff;
        endcase
    endfunction

    // reset state, empty-queue errors, extremes, order-keeping removal, full queue
    task automatic test_directed_corners();
        send_req(REQ_QUERY, 32'sd0);
        send_req(REQ_POP, 32'sd0);
        send_req(REQ_REMOVE, 32'sd0);
        send_req(REQ_PUSH, 32'sh7fff_ffff);
        send_req(REQ_PUSH, 32'sh8000_0000);
        send_req(REQ_PUSH, 32'sd0);
        send_req(REQ_PUSH, -32'sd1);
        send_req(REQ_REMOVE, 32'sd12345);
        send_req(REQ_PUSH, 32'sh8000_0000);
        send_req(REQ_REMOVE, 32'sh8000_0000);
        send_req(REQ_POP, 32'sh7fff_ffff);
        // fill to the brim with alternating bit patterns, then overflow
        for (int i = 0; i < DEPTH - 2; i++) begin
            send_req(REQ_PUSH, (i % 2) ? 32'sh5555_5555 : 32'shaaaa_aaaa);
        end
        send_req(REQ_PUSH, 32'sh1234_5678);
        send_req(REQ_REMOVE, 32'shaaaa_aaaa);
    endtask

    // random request mix that alternates between filling and draining
    task automatic run_random_traffic(int unsigned count, int unsigned snd_pct,
                                      int unsigned rcv_pct);
        int unsigned pick;
        t_req_code   kind;
        logic signed [31:0] val;
        snd_idle_pct  = snd_pct;
        rcv_stall_pct = rcv_pct;
        for (int unsigned n = 0; n < count; n++) begin
            if ($urandom_range(24) == 0) begin
                fill_trend = !fill_trend;
            end
            pick = $urandom_range(99);
            if (pick < (fill_trend ? 60 : 20)) begin
                kind = REQ_PUSH;
            end else if (pick < (fill_trend ? 75 : 70)) begin
                kind = REQ_POP;
            end else if (pick < 88) begin
                kind = REQ_REMOVE;
            end else begin
                kind = REQ_QUERY;
            end
            val = random_value();
            // removals mostly aim at a value actually held
            if (kind == REQ_REMOVE && model_held > 0 && $urandom_range(9) < 7) begin
                val = model_ring[ring_pos($urandom_range(model_held - 1))];
            end
            send_req(kind, val);
        end
    endtask

    task automatic test_streaming();
        run_random_traffic(360, 0, 0);
    endtask

    task automatic test_sender_gaps();
        run_random_traffic(360, 72, 0);
    endtask

    task automatic test_receiver_stalls();
        run_random_traffic(360, 0, 72);
    endtask

    task automatic test_mixed_idling();
        run_random_traffic(360, 29, 29);
    endtask

    // test sequence
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_corners();
        test_streaming();
        test_sender_gaps();
        wait_for_results();
        test_receiver_stalls();
        test_mixed_idling();
        wait_for_results();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // run limit
    initial begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
